// ----- design/hsv2rgb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the HSV to RGB converter.
// No dependencies; imported by every module of the block.

package hsv2rgb_pkg;

   localparam int unsigned HUE_W    = 15;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned REM_W    = 4;
   localparam int unsigned NUM_W    = 12;
   localparam int unsigned HI_W     = HUE_W - 8;
   localparam int unsigned SCALE_W  = 16;
   localparam int unsigned WIDE_W   = SCALE_W + CHAN_W;

   localparam logic [CHAN_W-1:0]  FULL_SCALE    = 8'd255;
   localparam logic [8:0]         FRAC_ONE      = 9'd256;
   localparam logic [SCALE_W-1:0] FRAC_SCALE    = 16'd65280;
   localparam logic [7:0]         STEPS_PER_HI  = 8'd15;
   localparam int unsigned        MAX_HI_QUOT   = 8;
   localparam logic [REM_W-1:0]   SECTOR_COUNT  = 4'd6;

   // x/15 for x < 3840: (x * 34953) >> 19
   localparam logic [15:0] DIV15_RECIP = 16'd34953;
   localparam int unsigned DIV15_SHIFT = 19;
   // y/255 for y < 65536: (y * 65794) >> 24, rounds up just enough to hit exact multiples
   localparam logic [16:0] DIV255_RECIP = 17'd65794;
   localparam int unsigned DIV255_SHIFT = 24;

   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type       sector;
      logic [REM_W-1:0] rem;
   } hue_split_type;

   typedef struct packed {
      sector_type        sector;
      logic [7:0]        frac;
      logic [CHAN_W-1:0] brightness;
      logic [CHAN_W-1:0] saturation;
   } frac_beat_type;

   typedef struct packed {
      sector_type         sector;
      logic [CHAN_W-1:0]  brightness;
      logic [WIDE_W-1:0]  q_prod;
      logic [WIDE_W-1:0]  t_prod;
      logic [SCALE_W-1:0] p_prod;
   } prod_beat_type;

   // Upper hue bits (hue >> 8) -> sector (quotient by 15, wrapped mod 6) and
   // the remainder by 15. Eight independent compares.
   function automatic hue_split_type split_hue(input logic [HI_W-1:0] hi);
      logic [REM_W-1:0] quot;
      logic [7:0]       base;
      hue_split_type    res;
      quot = '0;
      for (int k = 1; k <= MAX_HI_QUOT; k++) begin
         if ({1'b0, hi} >= 8'(k * 15)) quot = REM_W'(k);
      end
      base = 8'(quot) * STEPS_PER_HI;
      res.rem = REM_W'({1'b0, hi} - base);
      if (quot >= SECTOR_COUNT) begin
         res.sector = sector_type'(3'(quot - SECTOR_COUNT));
      end else begin
         res.sector = sector_type'(quot[2:0]);
      end
      return res;
   endfunction

   function automatic logic [CHAN_W-1:0] div_255(input logic [SCALE_W-1:0] y);
      logic [32:0] prod;
      prod = 33'(y) * 33'(DIV255_RECIP);
      return prod[DIV255_SHIFT +: CHAN_W];
   endfunction

endpackage

// ----- design/hsv2rgb_hue_split.sv -----
`timescale 1ns / 1ps
// Stages 1-2: hue split into sector and in-sector fraction (0..255).
// Depends on hsv2rgb_pkg.

module hsv2rgb_hue_split
   import hsv2rgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [HUE_W-1:0]  in_hue,
   input  logic [CHAN_W-1:0] in_brightness,
   input  logic [CHAN_W-1:0] in_saturation,
   output logic              out_valid,
   input  logic              out_ready,
   output frac_beat_type     out_beat
);

   logic              s1_vld_ff, s2_vld_ff;
   logic              en1, en2;
   sector_type        s1_sector_ff;
   logic [NUM_W-1:0]  s1_num_ff;
   logic [CHAN_W-1:0] s1_bright_ff, s1_sat_ff;
   hue_split_type     split_in;
   logic [NUM_W-1:0]  s1_num_in;
   logic [27:0]       frac_prod;
   frac_beat_type     s2_beat_ff, s2_beat_in;

   assign en2      = !s2_vld_ff || out_ready;
   assign en1      = !s1_vld_ff || en2;
   assign in_ready = en1;

   assign split_in  = split_hue(in_hue[HUE_W-1:8]);
   // hue mod 3840 = rem*256 + low byte
   assign s1_num_in = {split_in.rem, in_hue[7:0]};

   assign frac_prod = 28'(s1_num_ff) * 28'(DIV15_RECIP);

   always_comb begin
      s2_beat_in.sector     = s1_sector_ff;
      s2_beat_in.frac       = frac_prod[DIV15_SHIFT +: 8];
      s2_beat_in.brightness = s1_bright_ff;
      s2_beat_in.saturation = s1_sat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (en1) s1_vld_ff <= in_valid;
         if (en2) s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         s1_sector_ff <= split_in.sector;
         s1_num_ff    <= s1_num_in;
         s1_bright_ff <= in_brightness;
         s1_sat_ff    <= in_saturation;
      end
      if (en2 && s1_vld_ff) begin
         s2_beat_ff <= s2_beat_in;
      end
   end

   assign out_valid = s2_vld_ff;
   assign out_beat  = s2_beat_ff;

endmodule

// ----- design/hsv2rgb_scale.sv -----
`timescale 1ns / 1ps
// Stages 3-4: saturation products and the p product, then brightness
// products for q and t. Depends on hsv2rgb_pkg.

module hsv2rgb_scale
   import hsv2rgb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  frac_beat_type in_beat,
   output logic          out_valid,
   input  logic          out_ready,
   output prod_beat_type out_beat
);

   logic               s3_vld_ff, s4_vld_ff;
   logic               en3, en4;
   sector_type         s3_sector_ff;
   logic [CHAN_W-1:0]  s3_bright_ff;
   logic [SCALE_W-1:0] s3_qn_ff, s3_tn_ff, s3_pprod_ff;
   logic [SCALE_W-1:0] s3_qn_in, s3_tn_in, s3_pprod_in;
   logic [SCALE_W-1:0] fs_prod;
   logic [16:0]        ft_prod;
   prod_beat_type      s4_beat_ff, s4_beat_in;

   assign en4      = !s4_vld_ff || out_ready;
   assign en3      = !s3_vld_ff || en4;
   assign in_ready = en3;

   // f*s and (256-f)*s never exceed 65280, so the differences stay >= 0
   assign fs_prod     = SCALE_W'(in_beat.frac) * SCALE_W'(in_beat.saturation);
   assign ft_prod     = 17'(FRAC_ONE - 9'(in_beat.frac)) * 17'(in_beat.saturation);
   assign s3_qn_in    = FRAC_SCALE - fs_prod;
   assign s3_tn_in    = SCALE_W'(17'(FRAC_SCALE) - ft_prod);
   assign s3_pprod_in = SCALE_W'(in_beat.brightness)
                      * SCALE_W'(FULL_SCALE - in_beat.saturation);

   always_comb begin
      s4_beat_in.sector     = s3_sector_ff;
      s4_beat_in.brightness = s3_bright_ff;
      s4_beat_in.q_prod     = WIDE_W'(s3_bright_ff) * WIDE_W'(s3_qn_ff);
      s4_beat_in.t_prod     = WIDE_W'(s3_bright_ff) * WIDE_W'(s3_tn_ff);
      s4_beat_in.p_prod     = s3_pprod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         if (en3) s3_vld_ff <= in_valid;
         if (en4) s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && in_valid) begin
         s3_sector_ff <= in_beat.sector;
         s3_bright_ff <= in_beat.brightness;
         s3_qn_ff     <= s3_qn_in;
         s3_tn_ff     <= s3_tn_in;
         s3_pprod_ff  <= s3_pprod_in;
      end
      if (en4 && s3_vld_ff) begin
         s4_beat_ff <= s4_beat_in;
      end
   end

   assign out_valid = s4_vld_ff;
   assign out_beat  = s4_beat_ff;

endmodule

// ----- design/hsv2rgb_select.sv -----
`timescale 1ns / 1ps
// Stage 5: reciprocal divides for p, q, t and the six-way sector select
// into the output register. Depends on hsv2rgb_pkg.

module hsv2rgb_select
   import hsv2rgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  prod_beat_type     in_beat,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CHAN_W-1:0] out_red,
   output logic [CHAN_W-1:0] out_green,
   output logic [CHAN_W-1:0] out_blue
);

   logic              vld_ff, en;
   logic [CHAN_W-1:0] p_val, q_val, t_val, v_val;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic [CHAN_W-1:0] red_in, green_in, blue_in;

   assign en       = !vld_ff || out_ready;
   assign in_ready = en;

   // x/65280 == (x >> 8)/255
   assign p_val = div_255(in_beat.p_prod);
   assign q_val = div_255(in_beat.q_prod[WIDE_W-1:8]);
   assign t_val = div_255(in_beat.t_prod[WIDE_W-1:8]);
   assign v_val = in_beat.brightness;

   always_comb begin
      case (in_beat.sector)
         SEC_RED: begin
            red_in = v_val; green_in = t_val; blue_in = p_val;
         end
         SEC_YELLOW: begin
            red_in = q_val; green_in = v_val; blue_in = p_val;
         end
         SEC_GREEN: begin
            red_in = p_val; green_in = v_val; blue_in = t_val;
         end
         SEC_CYAN: begin
            red_in = p_val; green_in = q_val; blue_in = v_val;
         end
         SEC_BLUE: begin
            red_in = t_val; green_in = p_val; blue_in = v_val;
         end
         default: begin
            red_in = v_val; green_in = p_val; blue_in = q_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

// ----- design/hsv_to_rgb_converter.sv -----
`timescale 1ns / 1ps
// Top level of the HSV to RGB converter: saturation register and the
// five-stage pipeline. Depends on hsv2rgb_pkg and the hsv2rgb_* stages.

// Converts one HSV color (hue in 1/64 degree, brightness 0..255) per beat
// into an 8-bit RGB triple, using the saturation register (reset 255) for
// every conversion. Hue values at or beyond 360 degrees wrap around the
// circle. The pipeline has five register stages: hue split, sector
// fraction, saturation products, brightness products, then divide and
// sector select into the output register. A new beat is taken every
// clock cycle as long as rsp_ready keeps up, and each stage holds its
// own valid bit so bubbles are squeezed out under backpressure. Write
// csr_write_data only while the pipeline is empty.

module hsv_to_rgb_converter
   import hsv2rgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [CHAN_W-1:0] csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [CHAN_W-1:0] req_brightness,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAN_W-1:0] rsp_red,
   output logic [CHAN_W-1:0] rsp_green,
   output logic [CHAN_W-1:0] rsp_blue
);

   logic [CHAN_W-1:0] saturation_ff;
   logic              frac_valid, frac_ready;
   frac_beat_type     frac_beat;
   logic              prod_valid, prod_ready;
   prod_beat_type     prod_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         saturation_ff <= FULL_SCALE;
      end else if (csr_write_enable) begin
         saturation_ff <= csr_write_data;
      end
   end

   hsv2rgb_hue_split u_hue_split (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_hue        (req_hue),
      .in_brightness (req_brightness),
      .in_saturation (saturation_ff),
      .out_valid     (frac_valid),
      .out_ready     (frac_ready),
      .out_beat      (frac_beat)
   );

   hsv2rgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frac_valid),
      .in_ready  (frac_ready),
      .in_beat   (frac_beat),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_beat  (prod_beat)
   );

   hsv2rgb_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_beat   (prod_beat),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule
